// ===== sv/rgbhsv_pkg.sv =====
`timescale 1ns / 1ps

package rgbhsv_pkg;

   localparam int CH_W        = 8;
   localparam int HUE_W       = 16;
   localparam int HDEN_W      = 11;   // 6*d, at most 1530
   localparam int SDEN_W      = 9;    // 2*max, at most 510
   localparam int HUE_STEPS   = HUE_W;
   localparam int SAT_STEPS   = CH_W;
   localparam int QUEUE_DEPTH = 4;

   // one pixel after classification, as held in the queue
   typedef struct packed {
      logic [HDEN_W-1:0] hrem;    // partial remainder of the hue division
      logic [HDEN_W-1:0] hden;
      logic [HUE_W-1:0]  hlow;    // dividend bits still to bring down
      logic [SDEN_W-1:0] srem;
      logic [SDEN_W-1:0] sden;
      logic [CH_W-1:0]   slow;
      logic [CH_W-1:0]   value;
      logic              grey;
   } item_type;

   typedef struct packed {
      item_type         it;
      logic [HUE_W-1:0] hq;
      logic [CH_W-1:0]  sq;
   } work_type;

   // one restoring step of the hue division
   function automatic work_type hue_step(work_type w);
      work_type        r;
      logic [HDEN_W:0] t;
      r = w;
      t = {w.it.hrem, w.it.hlow[HUE_W-1]};
      if (t >= {1'b0, w.it.hden}) begin
         r.it.hrem = HDEN_W'(t - {1'b0, w.it.hden});
         r.hq      = {w.hq[HUE_W-2:0], 1'b1};
      end else begin
         r.it.hrem = t[HDEN_W-1:0];
         r.hq      = {w.hq[HUE_W-2:0], 1'b0};
      end
      r.it.hlow = {w.it.hlow[HUE_W-2:0], 1'b0};
      return r;
   endfunction

   // one restoring step of the saturation division
   function automatic work_type sat_step(work_type w);
      work_type        r;
      logic [SDEN_W:0] t;
      r = w;
      t = {w.it.srem, w.it.slow[CH_W-1]};
      if (t >= {1'b0, w.it.sden}) begin
         r.it.srem = SDEN_W'(t - {1'b0, w.it.sden});
         r.sq      = {w.sq[CH_W-2:0], 1'b1};
      end else begin
         r.it.srem = t[SDEN_W-1:0];
         r.sq      = {w.sq[CH_W-2:0], 1'b0};
      end
      r.it.slow = {w.it.slow[CH_W-2:0], 1'b0};
      return r;
   endfunction

endpackage

// ===== sv/rgbhsv_front.sv =====
`timescale 1ns / 1ps

module rgbhsv_front
   import rgbhsv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic [CH_W-1:0] red,
   input  logic [CH_W-1:0] green,
   input  logic [CH_W-1:0] blue,
   output logic            item_valid,
   input  logic            item_taken,
   output item_type        item
);

   logic            vld_ff, vld_in;
   item_type        item_ff, item_in;
   logic [CH_W-1:0] mx, mn, d;
   logic [11:0]     hn, d6;
   logic [16:0]     snum;
   logic            load;

   assign in_ready   = !vld_ff || item_taken;
   assign load       = in_valid && in_ready;
   assign item_valid = vld_ff;
   assign item       = item_ff;

   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx)  mx = blue;
      if (green < mn) mn = green;
      if (blue < mn)  mn = blue;
      d  = mx - mn;
      d6 = {2'b0, d, 2'b0} + {3'b0, d, 1'b0};
      // sector by the largest channel, red then green winning ties
      if (red >= green && red >= blue) begin
         hn = {4'b0, green} - {4'b0, blue};
         if (hn[11]) hn = hn + d6;
      end else if (green >= blue) begin
         hn = {3'b0, d, 1'b0} + {4'b0, blue} - {4'b0, red};
      end else begin
         hn = {2'b0, d, 2'b0} + {4'b0, red} - {4'b0, green};
      end
      // 510*d + max over 2*max
      snum = {d, 9'b0} - {8'b0, d, 1'b0} + {9'b0, mx};
      item_in.hrem  = hn[HDEN_W-1:0];
      item_in.hden  = d6[HDEN_W-1:0];
      item_in.hlow  = HUE_W'({d, 1'b0}) + HUE_W'(d);
      item_in.srem  = snum[16:8];
      item_in.sden  = {mx, 1'b0};
      item_in.slow  = snum[7:0];
      item_in.value = mx;
      item_in.grey  = (d == '0);
      vld_in = load ? 1'b1 : (item_taken ? 1'b0 : vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (load) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== sv/rgbhsv_queue.sv =====
`timescale 1ns / 1ps

module rgbhsv_queue
   import rgbhsv_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type head
);

   localparam int AW = $clog2(DEPTH);

   item_type      mem_ff [DEPTH];
   logic [AW:0]   wr_ff, wr_in, rd_ff, rd_in;

   assign empty = (wr_ff == rd_ff);
   assign full  = (wr_ff[AW] != rd_ff[AW]) && (wr_ff[AW-1:0] == rd_ff[AW-1:0]);
   assign head  = mem_ff[rd_ff[AW-1:0]];
   assign wr_in = wr_ff + (AW+1)'(1);
   assign rd_in = rd_ff + (AW+1)'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_in;
         if (pop)  rd_ff <= rd_in;
      end
      if (push) begin
         mem_ff[wr_ff[AW-1:0]] <= push_item;
      end
   end

endmodule

// ===== sv/rgbhsv_back.sv =====
`timescale 1ns / 1ps

module rgbhsv_back
   import rgbhsv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   output logic             item_pop,
   input  item_type         item,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [HUE_W-1:0] hue,
   output logic [CH_W-1:0]  saturation,
   output logic [CH_W-1:0]  value
);

   work_type               stage_ff [HUE_STEPS];
   work_type               stage_in [HUE_STEPS];
   logic [HUE_STEPS-1:0]   vld_ff, vld_in;
   logic                   adv;
   work_type               entry;

   // whole divider line moves together whenever the last word can leave
   assign adv      = !vld_ff[HUE_STEPS-1] || out_ready;
   assign item_pop = adv && item_valid;

   always_comb begin
      entry.it = item;
      entry.hq = '0;
      entry.sq = '0;
      for (int i = 0; i < HUE_STEPS; i++) begin
         stage_in[i] = hue_step((i == 0) ? entry : stage_ff[(i == 0) ? 0 : i-1]);
         if (i < SAT_STEPS) stage_in[i] = sat_step(stage_in[i]);
      end
      vld_in = {vld_ff[HUE_STEPS-2:0], item_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
      if (adv) begin
         for (int i = 0; i < HUE_STEPS; i++) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign out_valid  = vld_ff[HUE_STEPS-1];
   assign hue        = stage_ff[HUE_STEPS-1].it.grey ? '0 : stage_ff[HUE_STEPS-1].hq;
   assign saturation = stage_ff[HUE_STEPS-1].it.grey ? '0 : stage_ff[HUE_STEPS-1].sq;
   assign value      = stage_ff[HUE_STEPS-1].it.value;

endmodule

// ===== sv/rgb_to_hsv_converter_top.sv =====
`timescale 1ns / 1ps

// rgb to hsv pixel converter
// req_ takes one pixel word (red, green, blue, 8 bits each) per accepted
// handshake; rsp_ gives one word per pixel with hue (16 bits, 65536 per
// turn), saturation and value, in the order the pixels came in.
// throughput: one pixel per clock, sustained, while rsp_tready stays high.
// path from acceptance on req_ to rsp_tvalid: the classify register takes
// the word at acceptance, then it passes through the queue and the 16 steps
// of the pipelined divider, which brings down one hue quotient bit per
// stage (the 8 saturation bits are done in its first 8 stages).
// when the receiver stalls, the divider line holds, the queue fills and
// req_tready falls once the queue and classify register are full; words
// already in flight are kept, none dropped.
// reset (synchronous, active high) empties the queue and the divider line;
// no word is valid after it.
module rgb_to_hsv_converter_top
   import rgbhsv_pkg::*;
#(
   parameter int QUEUE_DEPTH = rgbhsv_pkg::QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // hue [15:0], saturation [23:16], value [31:24]
);

   logic             f_valid, f_taken, q_full, q_empty, q_pop;
   item_type         f_item, q_head;
   logic [HUE_W-1:0] hue;
   logic [CH_W-1:0]  saturation, value;

   assign f_taken = f_valid && !q_full;

   rgbhsv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .red        (req_tdata[7:0]),
      .green      (req_tdata[15:8]),
      .blue       (req_tdata[23:16]),
      .item_valid (f_valid),
      .item_taken (f_taken),
      .item       (f_item)
   );

   rgbhsv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_taken),
      .push_item (f_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   rgbhsv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!q_empty),
      .item_pop   (q_pop),
      .item       (q_head),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .hue        (hue),
      .saturation (saturation),
      .value      (value)
   );

   assign rsp_tdata = {value, saturation, hue};

endmodule
